FILE: sv/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CHK_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define CHK_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: sv/bdlpe_pkg.sv
package bdlpe_pkg;

    localparam int NUM_KEYS   = 6;
    localparam int HOLD_W     = 8;
    localparam int CFG_W      = 8;

    // Button positions within button_levels
    localparam int KEY_OFF    = 0;
    localparam int KEY_CHARGE = 1;
    localparam int KEY_UP     = 2;
    localparam int KEY_DOWN   = 3;
    localparam int KEY_CLK    = 4;
    localparam int KEY_SELECT = 5;

    localparam logic [CFG_W-1:0] DEFAULT_SAMPLE_INTERVAL  = 8'd4;
    localparam logic [CFG_W-1:0] DEFAULT_LONG_PRESS_LIMIT = 8'd20;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_POLL = 1'b1
    } op_t;

    typedef enum logic {
        REG_SAMPLE_INTERVAL  = 1'b0,
        REG_LONG_PRESS_LIMIT = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_UP          = 3'd1,
        EV_DOWN        = 3'd2,
        EV_SELECT      = 3'd3,
        EV_BACK        = 3'd4,
        EV_OFF         = 3'd5,
        EV_SELECT_LONG = 3'd6,
        EV_CLK         = 3'd7
    } event_t;

    typedef struct packed {
        logic                op;
        logic [NUM_KEYS-1:0] button_levels;
    } in_word_t;

    typedef struct packed {
        logic [2:0] event_code;
    } out_word_t;

    typedef struct packed {
        logic              held;
        logic              press;
        logic              release_seen;
        logic [HOLD_W-1:0] hold;
    } key_status_t;

    typedef struct packed {
        logic press;
        logic release_seen;
        logic hold;
    } key_clear_t;

endpackage

FILE: sv/bdlpe_stream_if.sv
interface bdlpe_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/bdlpe_lane.sv
module bdlpe_lane (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample,
    input  logic                    level,
    input  bdlpe_pkg::key_clear_t   clr,
    output bdlpe_pkg::key_status_t  status
);
    import bdlpe_pkg::*;

    logic              last_reg, last_next;
    logic              held_reg, held_next;
    logic              press_reg, press_next;
    logic              rel_reg, rel_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;

    always_comb
    begin
        last_next  = last_reg;
        held_next  = held_reg;
        press_next = press_reg && !clr.press;
        rel_next   = rel_reg && !clr.release_seen;
        hold_next  = clr.hold ? '0 : hold_reg;
        if (sample)
        begin
            last_next = level;
            // act only on two equal samples in a row
            if (level == last_reg)
            begin
                if (!level)
                begin
                    held_next = 1'b1;
                    if (!held_reg)
                    begin
                        press_next = 1'b1;
                        hold_next  = HOLD_W'(1);
                    end
                    else
                    begin
                        hold_next = hold_reg + HOLD_W'(1);
                    end
                end
                else
                begin
                    held_next = 1'b0;
                    if (held_reg)
                    begin
                        rel_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= 1'b0;
            held_reg  <= 1'b0;
            press_reg <= 1'b0;
            rel_reg   <= 1'b0;
            hold_reg  <= '0;
        end
        else
        begin
            last_reg  <= last_next;
            held_reg  <= held_next;
            press_reg <= press_next;
            rel_reg   <= rel_next;
            hold_reg  <= hold_next;
        end
    end

    assign status.held         = held_reg;
    assign status.press        = press_reg;
    assign status.release_seen = rel_reg;
    assign status.hold         = hold_reg;

endmodule

FILE: sv/bdlpe_merge.sv
module bdlpe_merge (
    input  logic                              poll,
    input  logic [bdlpe_pkg::CFG_W-1:0]       limit,
    input  bdlpe_pkg::key_status_t            status [bdlpe_pkg::NUM_KEYS],
    output bdlpe_pkg::key_clear_t             clr    [bdlpe_pkg::NUM_KEYS],
    output bdlpe_pkg::event_t                 event_code
);
    import bdlpe_pkg::*;

    always_comb
    begin
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            clr[i] = '0;
        end
        event_code = EV_NONE;
        if (poll)
        begin
            priority if (status[KEY_UP].release_seen)
            begin
                event_code                   = EV_UP;
                clr[KEY_UP].release_seen     = 1'b1;
            end
            else if (status[KEY_DOWN].release_seen)
            begin
                event_code                   = EV_DOWN;
                clr[KEY_DOWN].release_seen   = 1'b1;
            end
            else if (status[KEY_SELECT].press && status[KEY_SELECT].hold < limit
                     && status[KEY_SELECT].release_seen)
            begin
                event_code                   = EV_SELECT;
                clr[KEY_SELECT]              = '1;
            end
            else if (status[KEY_SELECT].release_seen)
            begin
                // drop a select release that was consumed by a long press
                clr[KEY_SELECT].release_seen = 1'b1;
            end
            else if (status[KEY_OFF].release_seen && status[KEY_OFF].hold < limit)
            begin
                event_code                   = EV_BACK;
                clr[KEY_OFF].release_seen    = 1'b1;
            end
            else if (status[KEY_OFF].held && status[KEY_OFF].hold > limit)
            begin
                event_code                   = EV_OFF;
                clr[KEY_OFF].hold            = 1'b1;
            end
            else if (status[KEY_SELECT].held && status[KEY_SELECT].hold > limit)
            begin
                event_code                   = EV_SELECT_LONG;
                clr[KEY_SELECT]              = '1;
            end
            else if (status[KEY_CLK].release_seen)
            begin
                event_code                   = EV_CLK;
                clr[KEY_CLK].release_seen    = 1'b1;
            end
            else
            begin
                event_code                   = EV_NONE;
            end
        end
    end

endmodule

FILE: sv/button_debounce_long_press_events.sv
// Channel   Dir  Handshake      Payload
// item      in   valid/ready    op, button_levels
// result    out  valid/ready    event_code
//
// Every word yields one result word; one word is accepted per cycle while a queue entry is free.
// The result is registered in the output queue and leaves it in the cycle after acceptance at the earliest.
// A two-word output queue lets input flow on while a result waits; input stalls
// only when both queue entries are full.
// Reset clears all debounce state, flags, hold counts and the prescaler, and
// loads sample_interval = 4 and long_press_limit = 20.
module button_debounce_long_press_events (
    input  logic                         clk,
    input  logic                         rst_n,
    bdlpe_stream_if.sink                 item,
    bdlpe_stream_if.source               result,
    input  logic                         cfg_we,
    input  bdlpe_pkg::reg_index_t        cfg_index,
    input  logic [bdlpe_pkg::CFG_W-1:0]  cfg_data
);
    import bdlpe_pkg::*;

    logic [CFG_W-1:0] interval_reg;
    logic [CFG_W-1:0] limit_reg;
    logic [CFG_W-1:0] div_reg, div_next;

    in_word_t    in_word;
    logic        push, pop;
    logic        sample;
    logic        poll;
    event_t      ev;
    key_status_t status [NUM_KEYS];
    key_clear_t  clr    [NUM_KEYS];

    logic [1:0]  count_reg, count_next;
    logic [2:0]  head_reg, head_next;
    logic [2:0]  skid_reg, skid_next;

    assign in_word = item.payload;
    assign push    = item.valid && item.ready;
    assign pop     = result.valid && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= DEFAULT_SAMPLE_INTERVAL;
            limit_reg    <= DEFAULT_LONG_PRESS_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLE_INTERVAL:  interval_reg <= cfg_data;
                REG_LONG_PRESS_LIMIT: limit_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // prescaler: sample on every (interval+1)-th tick
    always_comb
    begin
        div_next = div_reg;
        sample   = 1'b0;
        if (push && in_word.op == OP_TICK)
        begin
            if (div_reg < interval_reg)
            begin
                div_next = div_reg + CFG_W'(1);
            end
            else
            begin
                div_next = '0;
                sample   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg <= '0;
        end
        else
        begin
            div_reg <= div_next;
        end
    end

    assign poll = push && in_word.op == OP_POLL;

    for (genvar g = 0; g < NUM_KEYS; g++)
    begin : g_lane
        bdlpe_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .sample (sample),
            .level  (in_word.button_levels[g]),
            .clr    (clr[g]),
            .status (status[g])
        );
    end

    bdlpe_merge u_merge (
        .poll       (poll),
        .limit      (limit_reg),
        .status     (status),
        .clr        (clr),
        .event_code (ev)
    );

    // two-entry output queue: head feeds the port, skid catches overflow
    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        skid_next  = skid_reg;
        if (pop)
        begin
            head_next = skid_reg;
        end
        if (push)
        begin
            if (count_reg == 2'd0 || (pop && count_reg == 2'd1))
            begin
                head_next = ev;
            end
            else
            begin
                skid_next = ev;
            end
        end
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign item.ready                = (count_reg != 2'd2);
    assign result.valid              = (count_reg != 2'd0);
    assign result.payload.event_code = head_reg;

endmodule

FILE: sv/bdlpe_checker.sv
`include "assert_macros.svh"

module bdlpe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic       item_op,
    input logic       result_valid,
    input logic       result_ready,
    input logic [2:0] result_code
);
    import bdlpe_pkg::*;

    `CHK_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_code))
    `CHK_IMPLY(a_empty_ready, clk, rst_n, !result_valid, item_ready)
    `CHK_NEXT(a_tick_none, clk, rst_n, item_valid && item_ready && item_op == OP_TICK && !result_valid, result_valid && result_code == EV_NONE)
    `CHK_NEXT(a_accept_shows, clk, rst_n, item_valid && item_ready, result_valid)

endmodule

bind button_debounce_long_press_events bdlpe_checker u_bdlpe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_op      (item.payload.op),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_code  (result.payload.event_code)
);
